FILE: rtl/lru_frame_replacement_unit_defines.svh
// ----------------------------------------------------------------------------
// LRU frame replacement unit assertion macros
// Shared forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_FRAME_REPLACEMENT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold starting in the cycle after the antecedent.
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU frame replacement package
// Sizes, request codes, sequencer states and the link memory command type.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

   // Number of physical frames that the order can hold.
   localparam int NUM_FRAMES = 64;
   // Address width of one frame and width of a link (one extra code for null).
   localparam int FRAME_W = $clog2(NUM_FRAMES);
   localparam int LINK_W  = FRAME_W + 1;
   // Width of the frame fields on the channels.
   localparam int FIELD_W = 6;
   // Link value that means no neighbor.
   localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NUM_FRAMES);

   // Request codes carried in req_type.
   typedef enum logic {
      REQ_REFERENCE = 1'b0,
      REQ_EVICT     = 1'b1
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_PLACE,
      ST_HEAD,
      ST_EVICT
   } seq_state_type;

   // One write port and one read port of a link memory.
   typedef struct packed {
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      logic [LINK_W-1:0]  wr_data;
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
   } ram_cmd_type;

   // True when a link names a real frame rather than null.
   function automatic logic is_frame(input logic [LINK_W-1:0] link);
      return link < LINK_W'(NUM_FRAMES);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lfr_req_if.sv
// ----------------------------------------------------------------------------
// LRU frame replacement request channel
// Valid/ready channel that carries one reference or evict item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_req_if;
   import lfr_pkg::*;

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [FIELD_W-1:0] frame_index;

   modport source (output valid, output req_type, output frame_index, input ready);
   modport sink   (input valid, input req_type, input frame_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfr_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU frame replacement response channel
// Valid/ready channel that carries one eviction result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_rsp_if;
   import lfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] victim_frame;
   logic               list_empty;

   modport source (output valid, output victim_frame, output list_empty, input ready);
   modport sink   (input valid, input victim_frame, input list_empty, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfr_link_ram.sv
// ----------------------------------------------------------------------------
// LRU frame replacement link memory
// Single write port, single read port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_link_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 7,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/lfr_sequencer.sv
// ----------------------------------------------------------------------------
// LRU frame replacement sequencer
// Walks each item through the link memories, keeps head, tail and tracked
// marks, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   lfr_req_if.sink              req_port,
   lfr_rsp_if.source            rsp_port,
   output lfr_pkg::ram_cmd_type newer_cmd,
   output lfr_pkg::ram_cmd_type older_cmd,
   input  logic [lfr_pkg::LINK_W-1:0] newer_rd_data,
   input  logic [lfr_pkg::LINK_W-1:0] older_rd_data
);
   import lfr_pkg::*;

   seq_state_type           state_ff, state_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [LINK_W-1:0]       head_ff, head_in;
   logic [LINK_W-1:0]       tail_ff, tail_in;
   logic [NUM_FRAMES-1:0]   tracked_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]      victim_ff, victim_in;
   logic                    empty_ff, empty_in;

   logic                    req_fire;
   logic                    req_evict;
   logic                    req_in_range;
   logic [FRAME_W-1:0]      req_addr;
   logic [LINK_W-1:0]       req_link;
   logic                    req_tracked;
   logic                    slot_free;
   logic                    rsp_load;
   logic                    trk_set;
   logic                    trk_clr;
   logic [FRAME_W-1:0]      trk_addr;
   logic [LINK_W-1:0]       frame_link;

   // Decode of the incoming item.
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign req_evict      = (req_port.req_type == REQ_EVICT);
   assign req_in_range   = 32'(req_port.frame_index) < 32'(NUM_FRAMES);
   assign req_addr       = FRAME_W'(req_port.frame_index);
   assign req_link       = LINK_W'(req_addr);
   assign req_tracked    = tracked_ff[req_addr];
   assign frame_link     = LINK_W'(frame_ff);
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_evict) begin
                  state_in = ST_EVICT;
               end else if (req_in_range && !req_tracked) begin
                  state_in = ST_PLACE;
               end else if (req_in_range && (req_link != head_ff)) begin
                  state_in = ST_UNLINK;
               end
            end
         end
         ST_UNLINK: begin
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            state_in = is_frame(head_ff) ? ST_HEAD : ST_IDLE;
         end
         ST_HEAD: begin
            state_in = ST_IDLE;
         end
         ST_EVICT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory commands, pointer updates, tracked marks and result loading.
   always_comb begin
      newer_cmd = '0;
      older_cmd = '0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      frame_in  = frame_ff;
      trk_set   = 1'b0;
      trk_clr   = 1'b0;
      trk_addr  = frame_ff;
      rsp_load  = 1'b0;
      victim_in = '0;
      empty_in  = 1'b0;

      // Both links of the named frame, or the tail's newer link, are read on accept.
      newer_cmd.rd_en   = req_fire;
      newer_cmd.rd_addr = req_evict ? tail_ff[FRAME_W-1:0] : req_addr;
      older_cmd.rd_en   = req_fire;
      older_cmd.rd_addr = req_addr;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               frame_in = req_addr;
               if (!req_evict && req_in_range && !req_tracked) begin
                  trk_set  = 1'b1;
                  trk_addr = req_addr;
               end
            end
         end
         ST_UNLINK: begin
            // Splice the frame out: each neighbor now points past it to the other.
            if (is_frame(older_rd_data)) begin
               newer_cmd.wr_en   = 1'b1;
               newer_cmd.wr_addr = older_rd_data[FRAME_W-1:0];
               newer_cmd.wr_data = newer_rd_data;
            end else begin
               tail_in = newer_rd_data;
            end
            if (is_frame(newer_rd_data)) begin
               older_cmd.wr_en   = 1'b1;
               older_cmd.wr_addr = newer_rd_data[FRAME_W-1:0];
               older_cmd.wr_data = older_rd_data;
            end else begin
               head_in = older_rd_data;
            end
         end
         ST_PLACE: begin
            // The frame becomes the newest entry.
            newer_cmd.wr_en   = 1'b1;
            newer_cmd.wr_addr = frame_ff;
            newer_cmd.wr_data = LINK_NIL;
            older_cmd.wr_en   = 1'b1;
            older_cmd.wr_addr = frame_ff;
            older_cmd.wr_data = head_ff;
            if (!is_frame(head_ff)) begin
               head_in = frame_link;
               tail_in = frame_link;
            end
         end
         ST_HEAD: begin
            // The previous head now has the frame as its newer neighbor.
            newer_cmd.wr_en   = 1'b1;
            newer_cmd.wr_addr = head_ff[FRAME_W-1:0];
            newer_cmd.wr_data = frame_link;
            head_in           = frame_link;
         end
         ST_EVICT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (is_frame(tail_ff)) begin
                  victim_in = FIELD_W'(tail_ff);
                  trk_clr   = 1'b1;
                  trk_addr  = tail_ff[FRAME_W-1:0];
                  tail_in   = newer_rd_data;
                  if (is_frame(newer_rd_data)) begin
                     older_cmd.wr_en   = 1'b1;
                     older_cmd.wr_addr = newer_rd_data[FRAME_W-1:0];
                     older_cmd.wr_data = LINK_NIL;
                  end else begin
                     head_in = LINK_NIL;
                  end
               end else begin
                  empty_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: a new item loads, otherwise it clears when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LINK_NIL;
         tail_ff      <= LINK_NIL;
         tracked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (trk_set) begin
            tracked_ff[trk_addr] <= 1'b1;
         end else if (trk_clr) begin
            tracked_ff[trk_addr] <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (rsp_load) begin
         victim_ff <= victim_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.victim_frame = victim_ff;
   assign rsp_port.list_empty   = empty_ff;

endmodule

`default_nettype wire

FILE: rtl/lru_frame_replacement_unit.sv
// ----------------------------------------------------------------------------
// LRU frame replacement unit
// Exact least-recently-used order over the physical frames, kept as a
// doubly linked list in two link memories.
// ----------------------------------------------------------------------------
// A reference item moves its frame to the most recent end of the order (an
// untracked frame is added there) and returns nothing; an evict item removes
// the least recent frame and returns it, or frame 0 with list_empty set when
// nothing is tracked. One item is in work at a time. A reference to a frame
// that is already newest, or out of range, ends on accept; a new frame is
// placed, and the previous head, if any, then gets it as its newer neighbor;
// moving a tracked frame reads its links with a registered read, then writes
// the newer-link memory while splicing it out (unless it is the tail), placing
// it and updating the previous head; that memory has a single write port and
// sets the pace. An evict also waits until the result register is free.
`default_nettype none

module lru_frame_replacement_unit (
   input  logic      clock,
   input  logic      reset,
   lfr_req_if.sink   req_port,
   lfr_rsp_if.source rsp_port
);
   import lfr_pkg::*;

   ram_cmd_type       newer_cmd;
   ram_cmd_type       older_cmd;
   logic [LINK_W-1:0] newer_rd_data;
   logic [LINK_W-1:0] older_rd_data;

   // Item sequencing, pointers and result register.
   lfr_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_port      (req_port),
      .rsp_port      (rsp_port),
      .newer_cmd     (newer_cmd),
      .older_cmd     (older_cmd),
      .newer_rd_data (newer_rd_data),
      .older_rd_data (older_rd_data)
   );

   // Links toward the more recent neighbor.
   lfr_link_ram #(
      .DEPTH (NUM_FRAMES),
      .WIDTH (LINK_W)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (newer_cmd.wr_en),
      .wr_addr (newer_cmd.wr_addr),
      .wr_data (newer_cmd.wr_data),
      .rd_en   (newer_cmd.rd_en),
      .rd_addr (newer_cmd.rd_addr),
      .rd_data (newer_rd_data)
   );

   // Links toward the less recent neighbor.
   lfr_link_ram #(
      .DEPTH (NUM_FRAMES),
      .WIDTH (LINK_W)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (older_cmd.wr_en),
      .wr_addr (older_cmd.wr_addr),
      .wr_data (older_cmd.wr_data),
      .rd_en   (older_cmd.rd_en),
      .rd_addr (older_cmd.rd_addr),
      .rd_data (older_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/lfr_checker.sv
// ----------------------------------------------------------------------------
// LRU frame replacement checker
// Port-level checks on eviction timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_frame_replacement_unit_defines.svh"

module lfr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_type,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lfr_pkg::FIELD_W-1:0] rsp_victim_frame,
   input logic                        rsp_list_empty
);
   import lfr_pkg::*;

   logic evict_fire;

   assign evict_fire = req_valid && req_ready && (req_type == REQ_EVICT);

   // A waiting result holds until it is taken.
   `LFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_victim_frame) && $stable(rsp_list_empty), "result changed while stalled")

   // An eviction into an empty result register reports once the evict state has loaded the result register.
   `LFR_ASSERT_NEXT(a_evict_latency, evict_fire && !rsp_valid, ##1 rsp_valid, "eviction result late")

   // The unit is busy in the cycle after it takes an eviction.
   `LFR_ASSERT_NEXT(a_evict_busy, evict_fire, !req_ready, "item taken during eviction")

   // An eviction taken as reset ends finds the order empty.
   `LFR_ASSERT_NEXT(a_evict_after_reset, evict_fire && $past(reset), ##1 (rsp_valid && rsp_list_empty), "eviction after reset not empty")

   // An empty report names frame zero.
   `LFR_ASSERT_SAME(a_empty_victim, rsp_valid && rsp_list_empty, rsp_victim_frame == '0, "empty result with nonzero frame")

endmodule

bind lru_frame_replacement_unit lfr_checker u_lfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .req_type         (req_port.req_type),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_victim_frame (rsp_port.victim_frame),
   .rsp_list_empty   (rsp_port.list_empty)
);

`default_nettype wire
